FILE: design/ggb_pkg.sv
// shared types, constants, saturation helpers and the microcode program
package ggb_pkg;

  // field and datapath widths
  localparam int SAMPLE_BITS   = 16;
  localparam int STATE_BITS    = 48;
  localparam int OUT_BITS      = 48;
  localparam int COEF_BITS     = 32;
  localparam int NUM_BITS      = 16;
  localparam int CFG_IDX_BITS  = 3;
  localparam int CFG_DATA_BITS = 32;
  localparam int Q_FRAC        = 30;
  localparam int SAMPLE_SHIFT  = 16;
  localparam int STEP_BITS     = 5;

  // split of the state operand for the shared multiplier
  localparam int LO_BITS   = STATE_BITS / 2;
  localparam int HI_BITS   = STATE_BITS - LO_BITS;
  localparam int PP_BITS   = LO_BITS + 1 + COEF_BITS;
  localparam int FULL_BITS = STATE_BITS + COEF_BITS + 1;
  localparam int SHR_BITS  = FULL_BITS - Q_FRAC;
  localparam int XS_BITS   = ((SAMPLE_BITS + SAMPLE_SHIFT) > STATE_BITS ?
                              SAMPLE_BITS + SAMPLE_SHIFT : STATE_BITS) + 1;

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;
  typedef logic signed [STATE_BITS-1:0]  state_t;
  typedef logic signed [STATE_BITS:0]    wide_t;
  typedef logic signed [OUT_BITS-1:0]    out_t;
  typedef logic signed [COEF_BITS-1:0]   coef_t;
  typedef logic        [NUM_BITS-1:0]    num_t;
  typedef logic        [STEP_BITS-1:0]   step_t;
  typedef logic signed [PP_BITS-1:0]     pp_t;
  typedef logic signed [FULL_BITS-1:0]   full_t;

  localparam state_t STATE_MAX = {1'b0, {(STATE_BITS-1){1'b1}}};
  localparam state_t STATE_MIN = {1'b1, {(STATE_BITS-1){1'b0}}};
  localparam out_t   OUT_MAX   = {1'b0, {(OUT_BITS-1){1'b1}}};
  localparam out_t   OUT_MIN   = {1'b1, {(OUT_BITS-1){1'b0}}};
  localparam full_t  Q30_HALF  = FULL_BITS'(64'd1 << (Q_FRAC - 1));

  // configuration register indexes
  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_NUM_SAMPLES = 3'd0,
    REG_B_COEF      = 3'd1,
    REG_C_RE        = 3'd2,
    REG_C_IM        = 3'd3,
    REG_D_RE        = 3'd4,
    REG_D_IM        = 3'd5
  } reg_idx_e;

  typedef struct packed {
    num_t  num_samples;
    coef_t b_coef;
    coef_t c_re;
    coef_t c_im;
    coef_t d_re;
    coef_t d_im;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    num_samples: NUM_BITS'(256),
    b_coef:      '0,
    c_re:        '0,
    c_im:        '0,
    d_re:        COEF_BITS'(64'd1 << Q_FRAC),
    d_im:        '0
  };

  // multiplier operand and coefficient selects
  typedef enum logic [1:0] {
    MA_S1  = 2'd0,
    MA_TRE = 2'd1,
    MA_TIM = 2'd2
  } ma_e;

  typedef enum logic [2:0] {
    MC_B   = 3'd0,
    MC_CRE = 3'd1,
    MC_CIM = 3'd2,
    MC_DRE = 3'd3,
    MC_DIM = 3'd4
  } mc_e;

  // adder operations
  typedef enum logic [3:0] {
    ALU_NONE    = 4'd0,
    ALU_ADD_P   = 4'd1,
    ALU_SUB_S2  = 4'd2,
    ALU_TRE     = 4'd3,
    ALU_TIM     = 4'd4,
    ALU_YRE_LD  = 4'd5,
    ALU_YRE_SUB = 4'd6,
    ALU_YIM_LD  = 4'd7,
    ALU_YIM_ADD = 4'd8
  } alu_e;

  // recursion state updates
  typedef enum logic [1:0] {
    SU_NONE  = 2'd0,
    SU_SHIFT = 2'd1,
    SU_CLEAR = 2'd2
  } su_e;

  typedef enum logic {
    JMP_NONE     = 1'b0,
    JMP_NOT_LAST = 1'b1
  } jmp_e;

  typedef struct packed {
    logic lo;
    logic hi;
    logic fin;
  } mul_op_t;

  typedef struct packed {
    mul_op_t mul;
    ma_e     ma;
    mc_e     mc;
    alu_e    alu;
    su_e     su;
    logic    emit;
    logic    done;
    jmp_e    jmp;
    step_t   target;
  } ctrl_t;

  typedef struct packed {
    logic last;
    logic out_full;
  } status_t;

  localparam ctrl_t CTRL_NOP = '{
    mul:    '{lo: 1'b0, hi: 1'b0, fin: 1'b0},
    ma:     MA_S1,
    mc:     MC_B,
    alu:    ALU_NONE,
    su:     SU_NONE,
    emit:   1'b0,
    done:   1'b0,
    jmp:    JMP_NONE,
    target: '0
  };

  localparam step_t STEP_SHIFT = STEP_BITS'(20);
  localparam step_t STEP_LAST  = STEP_BITS'(20);

  // a +/- b with one guard bit
  function automatic wide_t wide_add(state_t a, state_t b, logic sub);
    wide_t ax;
    wide_t bx;
    ax = (STATE_BITS+1)'(a);
    bx = (STATE_BITS+1)'(b);
    return sub ? wide_t'(ax - bx) : wide_t'(ax + bx);
  endfunction

  // clamp a sum to the state range
  function automatic state_t sat_sum(wide_t v);
    state_t r;
    if (v > STATE_MAX) r = STATE_MAX;
    else if (v < STATE_MIN) r = STATE_MIN;
    else r = v[STATE_BITS-1:0];
    return r;
  endfunction

  // clamp a sum to the result range
  function automatic out_t sat_out(wide_t v);
    out_t r;
    if (v > OUT_MAX) r = OUT_MAX;
    else if (v < OUT_MIN) r = OUT_MIN;
    else r = v[OUT_BITS-1:0];
    return r;
  endfunction

  // clamp a rounded, shifted product to the state range
  function automatic state_t sat_prod(logic signed [SHR_BITS-1:0] v);
    state_t r;
    if (v > STATE_MAX) r = STATE_MAX;
    else if (v < STATE_MIN) r = STATE_MIN;
    else r = v[STATE_BITS-1:0];
    return r;
  endfunction

  // integer sample to state format with 16 fraction bits
  function automatic state_t scale_sample(sample_t x);
    logic signed [XS_BITS-1:0] v;
    state_t r;
    v = XS_BITS'(x) <<< SAMPLE_SHIFT;
    if (v > STATE_MAX) r = STATE_MAX;
    else if (v < STATE_MIN) r = STATE_MIN;
    else r = v[STATE_BITS-1:0];
    return r;
  endfunction

  // microcode program: one control word per step
  function automatic ctrl_t ucode(step_t pc);
    ctrl_t c;
    c = CTRL_NOP;
    case (pc)
      // s1 * b
      5'd0: begin
        c.mul.lo = 1'b1; c.ma = MA_S1; c.mc = MC_B;
      end
      5'd1: begin
        c.mul.hi = 1'b1; c.ma = MA_S1; c.mc = MC_B;
      end
      5'd2: begin
        c.mul.fin = 1'b1;
      end
      // s0 = x + b*s1 - s2, start s1 * c_re early
      5'd3: begin
        c.alu = ALU_ADD_P;
      end
      5'd4: begin
        c.alu = ALU_SUB_S2; c.mul.lo = 1'b1; c.ma = MA_S1; c.mc = MC_CRE;
      end
      5'd5: begin
        c.mul.hi = 1'b1; c.ma = MA_S1; c.mc = MC_CRE;
        c.jmp = JMP_NOT_LAST; c.target = STEP_SHIFT;
      end
      // finalize: t = s0 - s1*c
      5'd6: begin
        c.mul.fin = 1'b1; c.mul.lo = 1'b1; c.ma = MA_S1; c.mc = MC_CIM;
      end
      5'd7: begin
        c.mul.hi = 1'b1; c.ma = MA_S1; c.mc = MC_CIM; c.alu = ALU_TRE;
      end
      5'd8: begin
        c.mul.fin = 1'b1;
      end
      5'd9: begin
        c.alu = ALU_TIM; c.mul.lo = 1'b1; c.ma = MA_TRE; c.mc = MC_DRE;
      end
      // y = t * d
      5'd10: begin
        c.mul.hi = 1'b1; c.ma = MA_TRE; c.mc = MC_DRE;
      end
      5'd11: begin
        c.mul.fin = 1'b1; c.mul.lo = 1'b1; c.ma = MA_TIM; c.mc = MC_DIM;
      end
      5'd12: begin
        c.mul.hi = 1'b1; c.ma = MA_TIM; c.mc = MC_DIM; c.alu = ALU_YRE_LD;
      end
      5'd13: begin
        c.mul.fin = 1'b1; c.mul.lo = 1'b1; c.ma = MA_TRE; c.mc = MC_DIM;
      end
      5'd14: begin
        c.mul.hi = 1'b1; c.ma = MA_TRE; c.mc = MC_DIM; c.alu = ALU_YRE_SUB;
      end
      5'd15: begin
        c.mul.fin = 1'b1; c.mul.lo = 1'b1; c.ma = MA_TIM; c.mc = MC_DRE;
      end
      5'd16: begin
        c.mul.hi = 1'b1; c.ma = MA_TIM; c.mc = MC_DRE; c.alu = ALU_YIM_LD;
      end
      5'd17: begin
        c.mul.fin = 1'b1;
      end
      5'd18: begin
        c.alu = ALU_YIM_ADD;
      end
      // hand the word over and restart the block
      5'd19: begin
        c.emit = 1'b1; c.su = SU_CLEAR; c.done = 1'b1;
      end
      // mid-block sample: advance the recursion
      5'd20: begin
        c.su = SU_SHIFT; c.done = 1'b1;
      end
      default: begin
        c.done = 1'b1;
      end
    endcase
    return c;
  endfunction

endpackage

FILE: design/ggb_mul.sv
// shared multiplier: state value times Q2.30 coefficient in two partial products
module ggb_mul import ggb_pkg::*; (
  input  logic    clk_i,
  input  mul_op_t op_i,
  input  state_t  a_i,
  input  coef_t   coef_i,
  output state_t  prod_o
);

  logic signed [LO_BITS:0] a_part;
  pp_t    pp_d;
  pp_t    pp_q;
  pp_t    lo_q;
  full_t  full;
  state_t prod_q;

  // low half unsigned, high half signed, one multiplier for both
  always_comb begin
    if (op_i.hi) begin
      a_part = (LO_BITS+1)'($signed(a_i[STATE_BITS-1:LO_BITS]));
    end else begin
      a_part = {1'b0, a_i[LO_BITS-1:0]};
    end
    pp_d = PP_BITS'(a_part) * PP_BITS'(coef_i);
  end

  // recombine, round half up, drop 30 fraction bits
  assign full = (FULL_BITS'(pp_q) <<< LO_BITS) + FULL_BITS'(lo_q) + Q30_HALF;

  always_ff @(posedge clk_i) begin
    if (op_i.lo || op_i.hi) begin
      pp_q <= pp_d;
    end
    if (op_i.hi) begin
      lo_q <= pp_q;
    end
    if (op_i.fin) begin
      prod_q <= sat_prod(full[FULL_BITS-1:Q_FRAC]);
    end
  end

  assign prod_o = prod_q;

endmodule

FILE: design/ggb_seq.sv
// microcode sequencer: step counter, program table and conditional jump
module ggb_seq import ggb_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    start_i,
  input  status_t status_i,
  output ctrl_t   ctrl_o,
  output logic    busy_o
);

  typedef enum logic [1:0] {
    SEQ_IDLE = 2'b01,
    SEQ_RUN  = 2'b10
  } seq_state_e;

  seq_state_e state_q;
  seq_state_e state_d;
  step_t      pc_q;
  step_t      pc_d;
  ctrl_t      rom_word;
  logic       go;

  // fetch and stall while the output word is still pending
  always_comb begin
    rom_word = ucode(pc_q);
    go       = (state_q == SEQ_RUN) && !(rom_word.emit && status_i.out_full);
    ctrl_o   = go ? rom_word : CTRL_NOP;
  end

  // next step
  always_comb begin
    state_d = state_q;
    pc_d    = pc_q;
    if (start_i) begin
      state_d = SEQ_RUN;
      pc_d    = '0;
    end else if (go) begin
      if (rom_word.done) begin
        state_d = SEQ_IDLE;
      end else if (rom_word.jmp == JMP_NOT_LAST && !status_i.last) begin
        pc_d = rom_word.target;
      end else begin
        pc_d = step_t'(pc_q + 1'b1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SEQ_IDLE;
      pc_q    <= '0;
    end else begin
      state_q <= state_d;
      pc_q    <= pc_d;
    end
  end

  assign busy_o = (state_q == SEQ_RUN);

  // an accepted sample always starts the program at step zero
  a_start_pc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |=> (state_q == SEQ_RUN) && (pc_q == '0))
    else $error("program did not start at step zero");

  // the step counter stays inside the program
  a_pc_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pc_q <= STEP_LAST)
    else $error("step counter ran past the program");

  // the recursion update ends the program
  a_shift_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == SEQ_RUN) && (pc_q == STEP_SHIFT) |=> (state_q == SEQ_IDLE))
    else $error("program continued after the state update");

endmodule

FILE: design/ggb_dp.sv
// datapath: recursion state, saturating adder, operand selects and output register
module ggb_dp import ggb_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    start_i,
  input  sample_t sample_i,
  input  cfg_t    cfg_i,
  input  ctrl_t   ctrl_i,
  input  logic    out_ready_i,
  output status_t status_o,
  output logic    out_valid_o,
  output out_t    out_re_o,
  output out_t    out_im_o
);

  state_t s1_q;
  state_t s2_q;
  num_t   count_q;
  state_t acc_q;
  state_t tim_q;
  state_t pa_q;
  out_t   y_re_q;
  out_t   y_im_q;
  out_t   out_re_q;
  out_t   out_im_q;
  logic   out_valid_q;

  state_t mul_a;
  coef_t  mul_coef;
  state_t prod;
  state_t opa;
  state_t opb;
  logic   sub;
  wide_t  sum;

  // multiplier operand selects
  always_comb begin
    case (ctrl_i.ma)
      MA_S1:   mul_a = s1_q;
      MA_TRE:  mul_a = acc_q;
      MA_TIM:  mul_a = tim_q;
      default: mul_a = s1_q;
    endcase
    case (ctrl_i.mc)
      MC_B:    mul_coef = cfg_i.b_coef;
      MC_CRE:  mul_coef = cfg_i.c_re;
      MC_CIM:  mul_coef = cfg_i.c_im;
      MC_DRE:  mul_coef = cfg_i.d_re;
      MC_DIM:  mul_coef = cfg_i.d_im;
      default: mul_coef = cfg_i.b_coef;
    endcase
  end

  ggb_mul u_mul (
    .clk_i  (clk_i),
    .op_i   (ctrl_i.mul),
    .a_i    (mul_a),
    .coef_i (mul_coef),
    .prod_o (prod)
  );

  // adder operand selects
  always_comb begin
    opa = acc_q;
    opb = prod;
    sub = 1'b0;
    case (ctrl_i.alu)
      ALU_ADD_P:   begin opa = acc_q; opb = prod; sub = 1'b0; end
      ALU_SUB_S2:  begin opa = acc_q; opb = s2_q; sub = 1'b1; end
      ALU_TRE:     begin opa = acc_q; opb = prod; sub = 1'b1; end
      ALU_TIM:     begin opa = '0;    opb = prod; sub = 1'b1; end
      ALU_YRE_SUB: begin opa = pa_q;  opb = prod; sub = 1'b1; end
      ALU_YIM_ADD: begin opa = pa_q;  opb = prod; sub = 1'b0; end
      default:     begin opa = acc_q; opb = prod; sub = 1'b0; end
    endcase
    sum = wide_add(opa, opb, sub);
  end

  // working registers
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      acc_q <= scale_sample(sample_i);
    end else if (ctrl_i.alu == ALU_ADD_P || ctrl_i.alu == ALU_SUB_S2 ||
                 ctrl_i.alu == ALU_TRE) begin
      acc_q <= sat_sum(sum);
    end
    if (ctrl_i.alu == ALU_TIM) begin
      tim_q <= sat_sum(sum);
    end
    if (ctrl_i.alu == ALU_YRE_LD || ctrl_i.alu == ALU_YIM_LD) begin
      pa_q <= prod;
    end
    if (ctrl_i.alu == ALU_YRE_SUB) begin
      y_re_q <= sat_out(sum);
    end
    if (ctrl_i.alu == ALU_YIM_ADD) begin
      y_im_q <= sat_out(sum);
    end
    if (ctrl_i.emit) begin
      out_re_q <= y_re_q;
      out_im_q <= y_im_q;
    end
  end

  // recursion state and sample count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_q    <= '0;
      s2_q    <= '0;
      count_q <= '0;
    end else begin
      case (ctrl_i.su)
        SU_SHIFT: begin
          s2_q    <= s1_q;
          s1_q    <= acc_q;
          count_q <= num_t'(count_q + 1'b1);
        end
        SU_CLEAR: begin
          s1_q    <= '0;
          s2_q    <= '0;
          count_q <= '0;
        end
        default: begin
        end
      endcase
    end
  end

  // output word register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ctrl_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // block end and output back-pressure
  assign status_o.last     = ((NUM_BITS+1)'(count_q) + 1'b1) >=
                             (NUM_BITS+1)'(cfg_i.num_samples);
  assign status_o.out_full = out_valid_q && !out_ready_i;

  assign out_valid_o = out_valid_q;
  assign out_re_o    = out_re_q;
  assign out_im_o    = out_im_q;

  // a finished word shows up on the output
  a_emit_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_i.emit |=> out_valid_o)
    else $error("finished word not presented");

  // a pending word is never overwritten
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    status_o.out_full |-> !ctrl_i.emit)
    else $error("pending output word overwritten");

  // the mid-block path is never taken on the block's last sample
  a_shift_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctrl_i.su == SU_SHIFT) |-> !status_o.last)
    else $error("state advanced on the last sample of a block");

endmodule

FILE: design/generalized_goertzel_bin.sv
// Single-bin generalized Goertzel analyzer, top level with configuration registers.
// A sample is accepted only while the block is idle. A sample inside a block runs the
// recursion steps of the microcode program and then the state update; the sample that
// ends a block runs the recursion and finalizing steps instead, and the step that hands
// the word over waits while the output register still holds an unaccepted word. The
// microcode program drives one shared 25x32 multiplier, which forms each state-times-
// coefficient product from two partial products and a rounding step; the recursion
// uses one product, the finalizing steps six. The output register holds a finished
// complex word while the next block's samples are already being taken.
module generalized_goertzel_bin import ggb_pkg::*; (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  sample_t                   sample_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output out_t                      out_re_o,
  output out_t                      out_im_o,
  input  logic                      cfg_we_i,
  input  logic [CFG_IDX_BITS-1:0]   cfg_idx_i,
  input  logic [CFG_DATA_BITS-1:0]  cfg_wdata_i
);

  cfg_t    cfg_q;
  ctrl_t   ctrl;
  status_t status;
  logic    busy;
  logic    start;

  // input handshake
  assign in_ready_o = !busy;
  assign start      = in_valid_i && in_ready_o;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= CFG_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_NUM_SAMPLES: cfg_q.num_samples <= cfg_wdata_i[NUM_BITS-1:0];
        REG_B_COEF:      cfg_q.b_coef      <= COEF_BITS'(cfg_wdata_i);
        REG_C_RE:        cfg_q.c_re        <= COEF_BITS'(cfg_wdata_i);
        REG_C_IM:        cfg_q.c_im        <= COEF_BITS'(cfg_wdata_i);
        REG_D_RE:        cfg_q.d_re        <= COEF_BITS'(cfg_wdata_i);
        REG_D_IM:        cfg_q.d_im        <= COEF_BITS'(cfg_wdata_i);
        default: begin
        end
      endcase
    end
  end

  ggb_seq u_seq (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start),
    .status_i (status),
    .ctrl_o   (ctrl),
    .busy_o   (busy)
  );

  ggb_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start),
    .sample_i    (sample_i),
    .cfg_i       (cfg_q),
    .ctrl_i      (ctrl),
    .out_ready_i (out_ready_i),
    .status_o    (status),
    .out_valid_o (out_valid_o),
    .out_re_o    (out_re_o),
    .out_im_o    (out_im_o)
  );

endmodule
